// ===== sv/mec_pkg.sv =====
package mec_pkg;

  localparam int unsigned FRAC_BITS  = 28;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned SIDE_W     = 13;
  localparam int unsigned ITER_W     = 10;
  localparam int unsigned SPAN_W     = 32;              // |right - left| fits unsigned 32
  localparam int unsigned DVD_W      = IDX_W + SPAN_W;  // |index * span|
  localparam int unsigned ADDR_W     = 5;
  localparam logic [SIDE_W-1:0] MAX_SIDE_C = SIDE_W'(4096);

  // |z|^2 <= 4.0 in Q(2*FRAC_BITS)
  localparam logic [63:0] ESC_BOUND = 64'd4 << (2 * FRAC_BITS);

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_LEFT   = 3'd2,
    REG_RIGHT  = 3'd3,
    REG_BOTTOM = 3'd4,
    REG_TOP    = 3'd5,
    REG_LIMIT  = 3'd6,
    REG_NONE   = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED_RE,
    ST_FEED_IM,
    ST_DIVIDE,
    ST_SQUARE,
    ST_UPDATE,
    ST_DONE
  } state_e;

  // one slot of the divider chain
  typedef struct packed {
    logic              valid;
    logic              tag;   // 0: real, 1: imaginary
    logic              neg;
    logic [DVD_W-1:0]  dvd;
    logic [DVD_W-1:0]  quo;
    logic [SIDE_W-1:0] rem;
    logic [SIDE_W-1:0] dvs;
  } div_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fff_ffff;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // four-band palette, every component mod 256
  function automatic rgb_t palette(input logic [ITER_W-1:0] n);
    rgb_t c;
    logic [11:0] nx;
    nx = {2'b00, n};
    c  = '0;
    if (nx < 12'd16) begin
      c.r = 8'((12'd16 - nx) << 4);
      c.b = 8'((nx << 4) - 12'd1);
    end else if (nx < 12'd32) begin
      c.g = 8'((nx - 12'd16) << 4);
      c.b = 8'(((12'd32 - nx) << 4) - 12'd1);
    end else if (nx < 12'd64) begin
      c.r = 8'((nx - 12'd32) << 3);
      c.g = 8'(((12'd64 - nx) << 3) - 12'd1);
    end else begin
      c.r = 8'(12'd255 - ((nx - 12'd64) << 2));
    end
    return c;
  endfunction

endpackage

// ===== sv/mandelbrot_escape_colorizer.sv =====
// Flow: the pixel is mapped through the divider chain (real part, then imaginary),
//   then each iteration squares, then adds and tests; a final square and test
//   ends the loop, and the result strobe follows from ST_DONE.
// One pixel at a time: busy stays high through the result strobe, so a new
//   request is taken only once the previous result is shown; the iteration loop sets how long.
// Reset: rst_ni (async, active low) returns to idle and loads the default frame;
//   the result is shown for exactly one cycle on done_o, the receiver cannot stall.
module mandelbrot_escape_colorizer import mec_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 start,
  output logic                 busy,
  input  logic [IDX_W-1:0]     column_i,
  input  logic [IDX_W-1:0]     pixel_row_i,
  // result channel
  output logic                 done_o,
  output logic [IDX_W-1:0]     column_out_o,
  output logic [IDX_W-1:0]     row_out_o,
  output logic signed [31:0]   point_re_o,
  output logic signed [31:0]   point_im_o,
  output logic [ITER_W-1:0]    iterations_o,
  output logic [7:0]           red_o,
  output logic [7:0]           green_o,
  output logic [7:0]           blue_o,
  output logic                 index_invalid_o,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // ---------------- configuration registers ----------------
  logic [SIDE_W-1:0]  width_q, height_q;
  logic signed [31:0] left_q, right_q, bottom_q, top_q;
  logic [ITER_W-1:0]  limit_q;
  reg_idx_e           reg_sel;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIDE_W'(640);
      height_q <= SIDE_W'(480);
      left_q   <= -32'sd536870912;
      right_q  <= 32'sd268435456;
      bottom_q <= -32'sd268435456;
      top_q    <= 32'sd268435456;
      limit_q  <= ITER_W'(128);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_WIDTH:  width_q  <= pwdata[SIDE_W-1:0];
        REG_HEIGHT: height_q <= pwdata[SIDE_W-1:0];
        REG_LEFT:   left_q   <= pwdata;
        REG_RIGHT:  right_q  <= pwdata;
        REG_BOTTOM: bottom_q <= pwdata;
        REG_TOP:    top_q    <= pwdata;
        REG_LIMIT:  limit_q  <= pwdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  prdata = {{(32-SIDE_W){1'b0}}, width_q};
      REG_HEIGHT: prdata = {{(32-SIDE_W){1'b0}}, height_q};
      REG_LEFT:   prdata = left_q;
      REG_RIGHT:  prdata = right_q;
      REG_BOTTOM: prdata = bottom_q;
      REG_TOP:    prdata = top_q;
      REG_LIMIT:  prdata = {{(32-ITER_W){1'b0}}, limit_q};
      default:    prdata = '0;
    endcase
  end

  // frame size clamped to the largest side; zero divides by one
  logic [SIDE_W-1:0] w_clamp, h_clamp;
  assign w_clamp = (width_q  > MAX_SIDE_C) ? MAX_SIDE_C : width_q;
  assign h_clamp = (height_q > MAX_SIDE_C) ? MAX_SIDE_C : height_q;

  // ---------------- control ----------------
  state_e state_q, state_d;
  logic   accept;
  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  logic [IDX_W-1:0]   col_q, row_q;
  logic               invalid_q;
  logic signed [31:0] cr_q, ci_q, zr_q, zi_q;
  logic [ITER_W-1:0]  n_q;
  logic signed [63:0] rr_q, ii_q, ri_q;

  // ---------------- mapping: |index * span| / size through the chain ----------------
  localparam int unsigned NCELL = DVD_W;
  div_t               chain [NCELL+1];
  div_t               feed;
  logic signed [32:0] span;
  logic               span_neg;
  logic [SPAN_W-1:0]  span_mag;
  logic [IDX_W-1:0]   feed_idx;
  logic [SIDE_W-1:0]  feed_size;
  logic               feed_im;

  assign feed_im = (state_q == ST_FEED_IM);

  always_comb begin
    if (feed_im) begin
      span      = 33'(top_q) - 33'(bottom_q);
      feed_idx  = row_q;
      feed_size = (h_clamp == '0) ? SIDE_W'(1) : h_clamp;
    end else begin
      span      = 33'(right_q) - 33'(left_q);
      feed_idx  = col_q;
      feed_size = (w_clamp == '0) ? SIDE_W'(1) : w_clamp;
    end
    span_neg = span[32];
    span_mag = span_neg ? SPAN_W'(-span) : SPAN_W'(span);
  end

  always_comb begin
    feed.valid = (state_q == ST_FEED_RE) || feed_im;
    feed.tag   = feed_im;
    feed.neg   = span_neg;
    feed.dvd   = DVD_W'(feed_idx) * DVD_W'(span_mag);
    feed.quo   = '0;
    feed.rem   = '0;
    feed.dvs   = feed_size;
  end

  assign chain[0] = feed;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    mec_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .in_i   (chain[k]),
      .out_o  (chain[k+1])
    );
  end

  // edge plus signed quotient, saturated to Q4.28
  div_t               dout;
  logic signed [63:0] q_signed, edge_lo;
  logic signed [31:0] mapped;
  assign dout     = chain[NCELL];
  assign q_signed = dout.neg ? -64'($unsigned(dout.quo)) : 64'($unsigned(dout.quo));
  assign edge_lo  = dout.tag ? 64'(bottom_q) : 64'(left_q);
  assign mapped   = sat32(edge_lo + q_signed);

  // ---------------- iteration datapath ----------------
  logic [63:0]        mag2;
  logic               in_radius;
  logic signed [63:0] diff, dsh, psh;
  logic signed [31:0] zr_next, zi_next;

  assign mag2      = $unsigned(rr_q) + $unsigned(ii_q);
  assign in_radius = (mag2 <= ESC_BOUND);
  assign diff      = rr_q - ii_q;
  assign dsh       = diff >>> FRAC_BITS;          // floor
  assign psh       = ri_q >>> (FRAC_BITS - 1);    // 2*re*im, floor
  assign zr_next   = sat32(dsh + 64'(cr_q));
  assign zi_next   = sat32(psh + 64'(ci_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (accept) state_d = ST_FEED_RE;
      ST_FEED_RE: state_d = ST_FEED_IM;
      ST_FEED_IM: state_d = ST_DIVIDE;
      ST_DIVIDE:  if (dout.valid && dout.tag) state_d = ST_SQUARE;
      ST_SQUARE:  state_d = ST_UPDATE;
      ST_UPDATE:  state_d = ((n_q < limit_q) && in_radius) ? ST_SQUARE : ST_DONE;
      ST_DONE:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q     <= column_i;
      row_q     <= pixel_row_i;
      invalid_q <= ({1'b0, column_i} >= w_clamp) || ({1'b0, pixel_row_i} >= h_clamp);
    end
    if (state_q == ST_DIVIDE && dout.valid) begin
      if (dout.tag) begin
        ci_q <= mapped;
      end else begin
        cr_q <= mapped;
      end
      zr_q <= '0;
      zi_q <= '0;
      n_q  <= '0;
    end
    if (state_q == ST_SQUARE) begin
      rr_q <= zr_q * zr_q;
      ii_q <= zi_q * zi_q;
      ri_q <= zr_q * zi_q;
    end
    if (state_q == ST_UPDATE && (n_q < limit_q) && in_radius) begin
      zr_q <= zr_next;
      zi_q <= zi_next;
      n_q  <= n_q + ITER_W'(1);
    end
  end

  // ---------------- result ----------------
  rgb_t color;
  assign color           = palette(n_q);
  assign done_o          = (state_q == ST_DONE);
  assign column_out_o    = col_q;
  assign row_out_o       = row_q;
  assign point_re_o      = cr_q;
  assign point_im_o      = ci_q;
  assign iterations_o    = n_q;
  assign red_o           = color.r;
  assign green_o         = color.g;
  assign blue_o          = color.b;
  assign index_invalid_o = invalid_q;

endmodule

// ===== sv/mec_div_cell.sv =====
module mec_div_cell import mec_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  div_t in_i,
  output div_t out_o
);

  div_t            nxt;
  logic [SIDE_W:0] trial;
  logic            fits;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    trial = {in_i.rem, in_i.dvd[DVD_W-1]};
    fits  = trial >= {1'b0, in_i.dvs};
    nxt   = in_i;
    nxt.dvd = {in_i.dvd[DVD_W-2:0], 1'b0};
    nxt.quo = {in_i.quo[DVD_W-2:0], fits};
    if (fits) begin
      nxt.rem = SIDE_W'(trial - {1'b0, in_i.dvs});
    end else begin
      nxt.rem = trial[SIDE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o <= '0;
    end else begin
      out_o <= nxt;
    end
  end

endmodule

// ===== sv/mec_checker.sv =====
module mec_checker import mec_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input logic [ITER_W-1:0] iterations_o,
  input logic [7:0]        green_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request accepted but not busy");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result shown while idle");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy)) else $error("result strobe longer than one cycle");

  a_first_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && iterations_o < ITER_W'(16)) |-> (green_o == 8'd0))
    else $error("first palette band has green");

endmodule

bind mandelbrot_escape_colorizer mec_checker u_mec_checker (.*);

// ===== tb/sv/tb_mandelbrot_escape_colorizer.sv =====
module tb_mandelbrot_escape_colorizer;
  import mec_pkg::*;

  // Expected pixel result, one per accepted request
  typedef struct {
    logic [IDX_W-1:0]   col;
    logic [IDX_W-1:0]   row;
    logic [31:0]        re;
    logic [31:0]        im;
    logic [ITER_W-1:0]  iters;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic               invalid;
  } pixel_t;

  // Pending request: a pixel, or a register write (driver handles both)
  typedef struct {
    logic               is_cfg;
    reg_idx_e           ridx;
    logic [31:0]        value;
    logic [IDX_W-1:0]   col;
    logic [IDX_W-1:0]   row;
    logic               drain;   // wait for all results after this entry
  } job_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [IDX_W-1:0] column_i = '0;
  logic [IDX_W-1:0] pixel_row_i = '0;
  logic done_o;
  logic [IDX_W-1:0] column_out_o, row_out_o;
  logic signed [31:0] point_re_o, point_im_o;
  logic [ITER_W-1:0] iterations_o;
  logic [7:0] red_o, green_o, blue_o;
  logic index_invalid_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  mandelbrot_escape_colorizer u_dut (
    .clk_i, .rst_ni, .start, .busy, .column_i, .pixel_row_i,
    .done_o, .column_out_o, .row_out_o, .point_re_o, .point_im_o,
    .iterations_o, .red_o, .green_o, .blue_o, .index_invalid_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor copy of the frame registers
  logic [SIDE_W-1:0] m_width  = 13'd640;
  logic [SIDE_W-1:0] m_height = 13'd480;
  logic signed [63:0] m_left = -64'sd536870912, m_right = 64'sd268435456;
  logic signed [63:0] m_bottom = -64'sd268435456, m_top = 64'sd268435456;
  logic [ITER_W-1:0] m_limit = 10'd128;

  job_t   jobs[$];
  pixel_t expected_pixels[$];
  int     errors = 0;
  bit     stim_done = 1'b0;
  bit     calm = 1'b0;        // no idling stretch

  function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // edge + idx*span/size, truncating division; zero size divides by one
  function automatic logic signed [63:0] map_point(input logic [IDX_W-1:0] idx,
      input logic [SIDE_W-1:0] size, input logic signed [63:0] lo,
      input logic signed [63:0] hi);
    logic signed [63:0] dv;
    dv = (size == 0) ? 64'sd1 : $signed({51'd0, size});
    return clip32(lo + ($signed({52'd0, idx}) * (hi - lo)) / dv);
  endfunction

  function automatic pixel_t escape_pixel(input logic [IDX_W-1:0] col,
      input logic [IDX_W-1:0] row);
    pixel_t p;
    logic [SIDE_W-1:0] w, h;
    logic signed [63:0] cr, ci, zr, zi, d, x;
    logic [63:0] mag;
    int n, lim;
    w = (m_width > MAX_SIDE_C) ? MAX_SIDE_C : m_width;
    h = (m_height > MAX_SIDE_C) ? MAX_SIDE_C : m_height;
    lim = m_limit;
    cr = map_point(col, w, m_left, m_right);
    ci = map_point(row, h, m_bottom, m_top);
    zr = 0; zi = 0; n = 0;
    forever begin
      mag = zr * zr + zi * zi;
      if (n >= lim || mag > (64'd4 << (2 * FRAC_BITS))) break;
      d = zr * zr - zi * zi;
      x = zr * zi;
      zr = clip32((d >>> FRAC_BITS) + cr);
      zi = clip32((x >>> (FRAC_BITS - 1)) + ci);
      n++;
    end
    p.col = col; p.row = row; p.re = cr[31:0]; p.im = ci[31:0];
    p.iters = n[ITER_W-1:0];
    if (n < 16) begin
      p.r = 8'(16 * (16 - n)); p.g = 8'd0; p.b = 8'(16 * n - 1);
    end else if (n < 32) begin
      p.r = 8'd0; p.g = 8'(16 * (n - 16)); p.b = 8'(16 * (32 - n) - 1);
    end else if (n < 64) begin
      p.r = 8'(8 * (n - 32)); p.g = 8'(8 * (64 - n) - 1); p.b = 8'd0;
    end else begin
      p.r = 8'(255 - 4 * (n - 64)); p.g = 8'd0; p.b = 8'd0;
    end
    p.invalid = (col >= w) || (row >= h);
    return p;
  endfunction

  task automatic apply_reg(input reg_idx_e ridx, input logic [31:0] v);
    case (ridx)
      REG_WIDTH:  m_width  = v[SIDE_W-1:0];
      REG_HEIGHT: m_height = v[SIDE_W-1:0];
      REG_LEFT:   m_left   = $signed(v);
      REG_RIGHT:  m_right  = $signed(v);
      REG_BOTTOM: m_bottom = $signed(v);
      REG_TOP:    m_top    = $signed(v);
      REG_LIMIT:  m_limit  = v[ITER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic add_pixel(input int c, input int r);
    job_t j;
    j = '{1'b0, REG_NONE, 32'd0, c[IDX_W-1:0], r[IDX_W-1:0], 1'b0};
    jobs.push_back(j);
  endtask

  task automatic add_reg(input reg_idx_e ridx, input logic [31:0] v);
    job_t j;
    j = '{1'b1, ridx, v, '0, '0, 1'b1};
    jobs.push_back(j);
  endtask

  task automatic add_pause();
    if (jobs.size() > 0) jobs[jobs.size()-1].drain = 1'b1;
  endtask

  // Driver: pixels via start/busy, register writes via APB setup+access
  int apb_phase = 0;
  bit draining = 1'b0;
  int settle = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (apb_phase == 1) begin
        penable <= 1'b1; apb_phase = 2;
      end else if (apb_phase == 2) begin
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; apb_phase = 0;
        void'(jobs.pop_front());
      end else if (start && !busy) begin
        // current pixel accepted at this edge
        expected_pixels.push_back(escape_pixel(column_i, pixel_row_i));
        if (jobs[0].drain) draining = 1'b1;
        void'(jobs.pop_front());
        start <= 1'b0;
      end else if (start) begin
        // hold request until accepted
      end else if (draining) begin
        if (expected_pixels.size() == 0 && !busy) begin
          if (settle < 8) settle++;
          else begin settle = 0; draining = 1'b0; end
        end
      end else if (jobs.size() > 0 && (calm || $urandom_range(99) >= 23)) begin
        if (jobs[0].is_cfg) begin
          if (expected_pixels.size() == 0 && !busy) begin
            apply_reg(jobs[0].ridx, jobs[0].value);
            psel <= 1'b1; pwrite <= 1'b1;
            paddr <= ADDR_W'({jobs[0].ridx, 2'b00});
            pwdata <= jobs[0].value;
            apb_phase = 1;
          end
        end else begin
          column_i <= jobs[0].col;
          pixel_row_i <= jobs[0].row;
          start <= 1'b1;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
      input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // Monitor: results cannot be held off, each strobe is one result
  always @(posedge clk_i) begin
    pixel_t e;
    if (rst_ni && done_o) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result col", column_out_o, 0);
      end else begin
        e = expected_pixels.pop_front();
        if (column_out_o !== e.col) report_mismatch("column", column_out_o, e.col);
        if (row_out_o !== e.row) report_mismatch("row", row_out_o, e.row);
        if (point_re_o !== e.re) report_mismatch("point_re", point_re_o, e.re);
        if (point_im_o !== e.im) report_mismatch("point_im", point_im_o, e.im);
        if (iterations_o !== e.iters) report_mismatch("iterations", iterations_o, e.iters);
        if (red_o !== e.r) report_mismatch("red", red_o, e.r);
        if (green_o !== e.g) report_mismatch("green", green_o, e.g);
        if (blue_o !== e.b) report_mismatch("blue", blue_o, e.b);
        if (index_invalid_o !== e.invalid)
          report_mismatch("index_invalid", index_invalid_o, e.invalid);
      end
    end
  end

  task automatic random_frame();
    int k;
    k = $urandom_range(9);
    // mostly small frames and low limits keep the run short
    add_reg(REG_WIDTH, (k == 0) ? $urandom_range(8191) : $urandom_range(64, 1));
    add_reg(REG_HEIGHT, (k == 1) ? $urandom_range(8191) : $urandom_range(64, 1));
    add_reg(REG_LEFT, (k == 2) ? $urandom : 32'(-$urandom_range(32'h2000_0000)));
    add_reg(REG_RIGHT, (k == 3) ? $urandom : $urandom_range(32'h1000_0000));
    add_reg(REG_BOTTOM, (k == 4) ? $urandom : 32'(-$urandom_range(32'h1400_0000)));
    add_reg(REG_TOP, (k == 5) ? $urandom : $urandom_range(32'h1400_0000));
    add_reg(REG_LIMIT, (k == 6) ? $urandom_range(1023) : $urandom_range(100));
  endtask

  initial begin
    int i, p;
    int unsigned u;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset frame, corners and out-of-frame indices
    add_pixel(0, 0); add_pixel(639, 479); add_pixel(320, 240); add_pixel(480, 240);
    add_pixel(640, 0); add_pixel(0, 480); add_pixel(4095, 4095);
    add_pause();
    // limit zero, extreme edges, zero size, oversize frame
    add_reg(REG_LIMIT, 0); add_pixel(5, 5);
    add_reg(REG_WIDTH, 0); add_reg(REG_HEIGHT, 8191);
    add_reg(REG_LEFT, 32'h8000_0000); add_reg(REG_RIGHT, 32'h7fff_ffff);
    add_reg(REG_BOTTOM, 32'h7fff_ffff); add_reg(REG_TOP, 32'h8000_0000);
    add_pixel(0, 0); add_pixel(4095, 4095); add_pixel(2048, 4095);
    add_reg(REG_LIMIT, 1023); add_reg(REG_WIDTH, 4096); add_reg(REG_HEIGHT, 4096);
    add_reg(REG_LEFT, 0); add_reg(REG_RIGHT, 0);
    add_reg(REG_BOTTOM, 0); add_reg(REG_TOP, 0);
    add_pixel(0, 0); add_pixel(4095, 0);       // origin: full limit
    add_reg(REG_LIMIT, 40); add_reg(REG_LEFT, 32'hE000_0000);
    add_reg(REG_RIGHT, 32'h1000_0000); add_reg(REG_BOTTOM, 32'hF000_0000);
    add_reg(REG_TOP, 32'h1000_0000);
    for (i = 0; i < 8; i++) add_pixel($urandom_range(4095), $urandom_range(4095));

    // random phases, each with a fresh frame
    for (p = 0; p < 24; p++) begin
      random_frame();
      for (i = 0; i < 38; i++) begin
        u = $urandom_range(9);
        if (u == 0) add_pixel($urandom_range(4095), $urandom_range(4095));
        else add_pixel($urandom_range(63), $urandom_range(63));
      end
      if (p == 10) add_pause();
    end
    // closing phase hits the largest limit once more
    add_reg(REG_LIMIT, 1023);
    add_pixel(1, 1);
    add_pixel(12'hfff, 12'h000);
    add_pixel(12'h000, 12'hfff);
    stim_done = 1'b1;
  end

  // idling-free stretch in the middle of the run
  initial begin
    #120000 calm = 1'b1;
    #60000  calm = 1'b0;
  end

  initial begin
    wait (stim_done && jobs.size() == 0 && !start && apb_phase == 0);
    wait (expected_pixels.size() == 0);
    repeat (2200) @(posedge clk_i);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // pixels that never escape at the largest limit take longest; the run stops as failed after the time limit
  initial begin
    #40000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
